>>> rtl/sync_framed_packet_deframer_assert.svh
// Assertion macros for the sync-framed packet deframer.
`ifndef SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sfpd_pkg.sv
// Package: phase and role codes, register indexes and the frame status struct.
package sfpd_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SYNC_FIRST  = 1'd0;
	localparam cfg_idx_t CFG_SYNC_SECOND = 1'd1;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

	typedef enum logic [3:0] {
		PH_SYNC1   = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LENLO   = 4'd4,
		PH_LENHI   = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CKA     = 4'd7,
		PH_CKB     = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_HUNT    = 4'd0,
		ROLE_SYNC1   = 4'd1,
		ROLE_SYNC2   = 4'd2,
		ROLE_CLASS   = 4'd3,
		ROLE_ID      = 4'd4,
		ROLE_LENLO   = 4'd5,
		ROLE_LENHI   = 4'd6,
		ROLE_PAYLOAD = 4'd7,
		ROLE_CKA     = 4'd8,
		ROLE_CKB     = 4'd9
	} role_t;

	typedef struct packed {
		role_t       role;
		logic [15:0] offset;
		logic [7:0]  frame_class;
		logic [7:0]  frame_id;
		logic [15:0] frame_length;
		logic        frame_end;
		logic        checksum_ok;
	} frame_info_t;

endpackage

>>> rtl/sfpd_ifs.sv
// Stream interfaces: received bytes in, tagged bytes with frame status out.
interface sfpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfpd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [3:0]  byte_role;
	logic [15:0] payload_offset;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [15:0] frame_length;
	logic        frame_end;
	logic        checksum_ok;
	logic [15:0] good_frames;
	logic [15:0] checksum_failures;

	modport source (
		output valid, output data_byte, output byte_role, output payload_offset,
		output frame_class, output frame_id, output frame_length, output frame_end,
		output checksum_ok, output good_frames, output checksum_failures,
		input ready
	);
	modport sink (
		input valid, input data_byte, input byte_role, input payload_offset,
		input frame_class, input frame_id, input frame_length, input frame_end,
		input checksum_ok, input good_frames, input checksum_failures,
		output ready
	);
endinterface

>>> rtl/sync_framed_packet_deframer.sv
// A transferred byte shows its tagged result on the next cycle.
// Throughput: one byte per cycle; the per-byte parser update and the output
// register advance together whenever the result register is empty or drains.
// Reset: arst_n clears parser state, counters and output valid, and restores
// the sync byte registers to 0xB5 and 0x62; no clearing pass is needed.
module sync_framed_packet_deframer #(
	parameter int unsigned COUNTER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  sfpd_pkg::cfg_idx_t   cfg_index,
	input  logic [7:0]           cfg_wdata,
	sfpd_byte_if.sink            byte_ch,
	sfpd_result_if.source        result_ch
);
	import sfpd_pkg::*;

	logic [7:0]              sync_first_q;
	logic [7:0]              sync_second_q;
	logic                    accept;
	frame_info_t             info;
	logic [COUNTER_BITS-1:0] good_q;
	logic [COUNTER_BITS-1:0] bad_q;
	logic [COUNTER_BITS-1:0] good_d;
	logic [COUNTER_BITS-1:0] bad_d;
	logic [31:0]             good_ext;
	logic [31:0]             bad_ext;

	logic                    valid_q;
	logic [7:0]              data_q;
	frame_info_t             info_q;
	logic [15:0]             good_out_q;
	logic [15:0]             bad_out_q;

	// Sync byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata;
				CFG_SYNC_SECOND: sync_second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Take a byte whenever the result register is free or drains this cycle
	assign byte_ch.ready = !valid_q || result_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	sfpd_frame_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.rx_byte     (byte_ch.rx_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.info        (info)
	);

	// Frame counters, bumped on the closing checksum byte
	always_comb begin
		good_d = good_q;
		bad_d  = bad_q;
		if (info.frame_end) begin
			if (info.checksum_ok) begin
				good_d = good_q + 1'b1;
			end else begin
				bad_d = bad_q + 1'b1;
			end
		end
	end

	assign good_ext = 32'(good_d);
	assign bad_ext  = 32'(bad_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q <= '0;
			bad_q  <= '0;
		end else if (accept) begin
			good_q <= good_d;
			bad_q  <= bad_d;
		end
	end

	// Result register: load on transfer in, drop valid on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q     <= byte_ch.rx_byte;
			info_q     <= info;
			good_out_q <= good_ext[15:0];
			bad_out_q  <= bad_ext[15:0];
		end
	end

	assign result_ch.valid             = valid_q;
	assign result_ch.data_byte         = data_q;
	assign result_ch.byte_role         = info_q.role;
	assign result_ch.payload_offset    = info_q.offset;
	assign result_ch.frame_class       = info_q.frame_class;
	assign result_ch.frame_id          = info_q.frame_id;
	assign result_ch.frame_length      = info_q.frame_length;
	assign result_ch.frame_end         = info_q.frame_end;
	assign result_ch.checksum_ok       = info_q.checksum_ok;
	assign result_ch.good_frames       = good_out_q;
	assign result_ch.checksum_failures = bad_out_q;

	`include "sync_framed_packet_deframer_assert.svh"

	`SFPD_ASSERT_NOW(a_ok_only_at_end, clk, arst_n, result_ch.valid && result_ch.checksum_ok, result_ch.frame_end, "checksum_ok without frame_end")
	`SFPD_ASSERT_NOW(a_offset_payload_only, clk, arst_n, result_ch.valid && (info_q.role != ROLE_PAYLOAD), result_ch.payload_offset == 16'd0, "payload offset on non-payload byte")
	`SFPD_ASSERT_NEXT(a_good_count_step, clk, arst_n, accept && info.frame_end && info.checksum_ok, good_q == COUNTER_BITS'($past(good_q) + 1'b1), "good frame counter did not advance")
	`SFPD_ASSERT_NEXT(a_bad_count_step, clk, arst_n, accept && info.frame_end && !info.checksum_ok, bad_q == COUNTER_BITS'($past(bad_q) + 1'b1), "checksum failure counter did not advance")

endmodule

>>> rtl/sfpd_frame_fsm.sv
// Frame parser: sync hunt, header capture, payload count and Fletcher sums.
module sfpd_frame_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          sync_first,
	input  logic [7:0]          sync_second,
	output sfpd_pkg::frame_info_t info
);
	import sfpd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  ck_a_q, ck_a_d;

	logic [7:0]  acc_a;
	logic [7:0]  acc_b;
	logic [15:0] len_full;
	logic [15:0] cnt_inc;
	role_t       role;
	logic [15:0] offset;
	logic        frame_end;
	logic        ck_ok;

	// Running Fletcher sums with this byte folded in
	assign acc_a    = sum_a_q + rx_byte;
	assign acc_b    = sum_b_q + acc_a;
	assign len_full = {rx_byte, len_q[7:0]};
	assign cnt_inc  = cnt_q + 16'd1;

	// Next phase
	always_comb begin
		phase_d = PH_SYNC1;
		case (phase_q)
			PH_SYNC1:   phase_d = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
			PH_SYNC2:   phase_d = (rx_byte == sync_second) ? PH_CLASS : PH_SYNC1;
			PH_CLASS:   phase_d = PH_ID;
			PH_ID:      phase_d = PH_LENLO;
			PH_LENLO:   phase_d = PH_LENHI;
			PH_LENHI:   phase_d = (len_full != 16'd0) ? PH_PAYLOAD : PH_CKA;
			PH_PAYLOAD: phase_d = (cnt_inc >= len_q) ? PH_CKA : PH_PAYLOAD;
			PH_CKA:     phase_d = PH_CKB;
			PH_CKB:     phase_d = PH_SYNC1;
			default:    phase_d = (rx_byte == sync_first) ? PH_SYNC2 : PH_SYNC1;
		endcase
	end

	// Role tag, header fields, sums and checksum result
	always_comb begin
		class_d   = class_q;
		id_d      = id_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		ck_a_d    = ck_a_q;
		role      = ROLE_HUNT;
		offset    = 16'd0;
		frame_end = 1'b0;
		ck_ok     = 1'b0;
		case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == sync_first) begin
					role = ROLE_SYNC1;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == sync_second) begin
					role    = ROLE_SYNC2;
					class_d = 8'd0;
					id_d    = 8'd0;
					len_d   = 16'd0;
					cnt_d   = 16'd0;
					sum_a_d = 8'd0;
					sum_b_d = 8'd0;
					ck_a_d  = 8'd0;
				end
			end
			PH_CLASS: begin
				role    = ROLE_CLASS;
				class_d = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
			end
			PH_ID: begin
				role    = ROLE_ID;
				id_d    = rx_byte;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
			end
			PH_LENLO: begin
				role    = ROLE_LENLO;
				len_d   = {8'd0, rx_byte};
				sum_a_d = acc_a;
				sum_b_d = acc_b;
			end
			PH_LENHI: begin
				role    = ROLE_LENHI;
				len_d   = len_full;
				cnt_d   = 16'd0;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
			end
			PH_PAYLOAD: begin
				role    = ROLE_PAYLOAD;
				offset  = cnt_q;
				cnt_d   = cnt_inc;
				sum_a_d = acc_a;
				sum_b_d = acc_b;
			end
			PH_CKA: begin
				role   = ROLE_CKA;
				ck_a_d = rx_byte;
			end
			PH_CKB: begin
				role      = ROLE_CKB;
				frame_end = 1'b1;
				ck_ok     = (ck_a_q == sum_a_q) && (rx_byte == sum_b_q);
			end
			default: begin
				if (rx_byte == sync_first) begin
					role = ROLE_SYNC1;
				end
			end
		endcase
	end

	// Advance parser state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			class_q <= 8'd0;
			id_q    <= 8'd0;
			len_q   <= 16'd0;
			cnt_q   <= 16'd0;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
			ck_a_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			class_q <= class_d;
			id_q    <= id_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			ck_a_q  <= ck_a_d;
		end
	end

	assign info.role         = role;
	assign info.offset       = offset;
	assign info.frame_class  = class_d;
	assign info.frame_id     = id_d;
	assign info.frame_length = len_d;
	assign info.frame_end    = frame_end;
	assign info.checksum_ok  = ck_ok;

endmodule
